>>> design/c3s_pkg.sv
// ----------------------------------------------------------------------------
// c3s_pkg - shared types and constants for the 3x3 stream convolution
// Field widths, configuration register codes and the control structs
// passed between the top level and its window cells and grid units.
// ----------------------------------------------------------------------------
package c3s_pkg;

  // default sizing
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CHANNELS_DEF  = 3;

  // port field widths
  localparam int SAMPLE_W  = 8;
  localparam int COEF_W    = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;
  localparam int FW_W      = 11;
  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 10;
  localparam int SUM_OUT_W = 29;

  // configuration register index
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEFF_TOP = 3'd0,
    CFG_COEFF_MID = 3'd1,
    CFG_COEFF_BOT = 3'd2,
    CFG_STEP      = 3'd3,
    CFG_FRAME_W   = 3'd4,
    CFG_FRAME_H   = 3'd5
  } cfg_idx_t;

  // pipeline load controls
  typedef struct packed {
    logic accept;  // pixel beat taken, first stage loads
    logic ld2;     // second stage loads
  } c3s_ctl_t;

  // stride grid decision for one axis
  typedef struct packed {
    logic hit;   // on the grid and inside the output range
    logic last;  // last output index along this axis
  } c3s_grid_t;

endpackage

>>> design/c3s_line_mem.sv
// ----------------------------------------------------------------------------
// c3s_line_mem - line store memory
// One write port and one registered read port; each word holds the two
// previous rows at one column.
// ----------------------------------------------------------------------------
module c3s_line_mem #(
  parameter int DEPTH = c3s_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 20
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/c3s_cell.sv
// ----------------------------------------------------------------------------
// c3s_cell - one window column cell
// Holds one column of three channel-summed pixels, hands it to its left
// neighbor on every pixel beat and forms the column's coefficient sum.
// ----------------------------------------------------------------------------
module c3s_cell #(
  parameter int SUM_W  = 10,
  parameter int PROD_W = c3s_pkg::COEF_W + SUM_W + 1,
  parameter int PSUM_W = PROD_W + 2
) (
  input  logic                                    clk,
  input  c3s_pkg::c3s_ctl_t                       ctl,
  input  logic [2:0][c3s_pkg::COEF_W-1:0]         coef_i,
  input  logic [2:0][SUM_W-1:0]                   col_i,
  output logic [2:0][SUM_W-1:0]                   col_o,
  output logic signed [PSUM_W-1:0]                psum_o
);

  logic [2:0][SUM_W-1:0]    col_r;
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [PSUM_W-1:0] psum_r;
  logic signed [PSUM_W-1:0] psum_nxt;

  // column shift and tap products of the incoming column
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      col_r <= col_i;
      for (int r = 0; r < 3; r++) begin
        prod_r[r] <= $signed(coef_i[r]) * $signed({1'b0, col_i[r]});
      end
    end
  end

  // column partial sum
  always_comb begin
    psum_nxt = PSUM_W'(prod_r[0]) + PSUM_W'(prod_r[1]) + PSUM_W'(prod_r[2]);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      psum_r <= psum_nxt;
    end
  end

  assign col_o  = col_r;
  assign psum_o = psum_r;

endmodule

>>> design/c3s_grid_div.sv
// ----------------------------------------------------------------------------
// c3s_grid_div - stride grid test for one axis
// Divides the offset by the stride through a reciprocal multiply, then
// checks the remainder and the output range against the axis limit.
// ----------------------------------------------------------------------------
module c3s_grid_div #(
  parameter int X_W = 16
) (
  input  logic                        clk,
  input  c3s_pkg::c3s_ctl_t           ctl,
  input  logic [c3s_pkg::STEP_W-1:0]  step_i,
  input  logic [X_W-1:0]              lim_i,
  input  logic [X_W-1:0]              x_i,
  output logic [X_W-1:0]              q_o,
  output c3s_pkg::c3s_grid_t          grid_o
);

  // exact for x below 2**X_W and strides up to seven
  localparam int K   = X_W + 3;
  localparam int M_W = K + 1;
  localparam int P   = 2 ** K;
  localparam int E_W = X_W + 4;

  logic [X_W-1:0]     x1_r;
  logic [X_W-1:0]     x2_r;
  logic [X_W-1:0]     q2_r;
  logic [M_W-1:0]     recip;
  logic [X_W+M_W-1:0] prod;
  logic [E_W-1:0]     qs;
  logic [E_W-1:0]     x_ext;
  logic [E_W-1:0]     lim_ext;
  logic [E_W-1:0]     s_ext;

  // ceil(2**K / stride)
  always_comb begin
    case (step_i)
      3'd2:    recip = M_W'((P + 1) / 2);
      3'd3:    recip = M_W'((P + 2) / 3);
      3'd4:    recip = M_W'((P + 3) / 4);
      3'd5:    recip = M_W'((P + 4) / 5);
      3'd6:    recip = M_W'((P + 5) / 6);
      3'd7:    recip = M_W'((P + 6) / 7);
      default: recip = M_W'(P);
    endcase
  end

  assign prod = x1_r * recip;

  // offset capture, then quotient
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x1_r <= x_i;
    end
    if (ctl.ld2) begin
      x2_r <= x1_r;
      q2_r <= prod[K +: X_W];
    end
  end

  // remainder zero and range checks
  always_comb begin
    x_ext   = E_W'(x2_r);
    lim_ext = E_W'(lim_i);
    s_ext   = E_W'(step_i);
    qs      = E_W'(q2_r) * s_ext;
    grid_o.hit  = (qs == x_ext) && (x_ext + s_ext <= lim_ext);
    grid_o.last = (x_ext + (s_ext << 1)) > lim_ext;
  end

  assign q_o = q2_r;

endmodule

>>> design/conv3x3_multichannel_stream_unit.sv
// ----------------------------------------------------------------------------
// conv3x3_multichannel_stream_unit - strided 3x3 convolution on a pixel stream
// Pixels enter in raster order on the in_ channel (valid/stall), one pixel
// of up to three 8-bit samples per beat. Each window on the stride grid
// yields one beat on the out_ channel: the signed sum of all 27 products,
// its output row and column and a flag on the last result of the frame.
// Throughput is one pixel per clock while out_ is not stalled: a three-cell
// window column chain and a three-stage result pipeline take a new pixel every
// cycle. A result moves from the first stage to the second and then into the
// output register. Stall on out_ holds the output register; bubbles in the pipe
// still let pixels in, and in_stall rises only once every stage is full.
// The user must write configuration on cfg_ only while no beat is in flight;
// the block does not enforce this. Reset clears the counters, the pipe and the
// registers (stride one, 50 x 50 frame, zero kernel); the line stores are not
// cleared and the first two rows of a frame only fill them.
// ----------------------------------------------------------------------------
module conv3x3_multichannel_stream_unit #(
  parameter int MAX_WIDTH = c3s_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS  = c3s_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [c3s_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [c3s_pkg::CFG_W-1:0]      cfg_wdata,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [c3s_pkg::SAMPLE_W-1:0]   in_sample_ch0,
  input  logic [c3s_pkg::SAMPLE_W-1:0]   in_sample_ch1,
  input  logic [c3s_pkg::SAMPLE_W-1:0]   in_sample_ch2,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [c3s_pkg::SUM_OUT_W-1:0]  out_window_sum,
  output logic [c3s_pkg::ROW_W-1:0]      out_row,
  output logic [c3s_pkg::OUT_COL_W-1:0]  out_col,
  output logic                           out_frame_last
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int SUM_W     = c3s_pkg::SAMPLE_W + $clog2(CHANNELS + 1);
  localparam int PROD_W    = c3s_pkg::COEF_W + SUM_W + 1;
  localparam int PSUM_W    = PROD_W + 2;
  localparam int ROW_W     = c3s_pkg::ROW_W;
  localparam int OUT_COL_W = c3s_pkg::OUT_COL_W;
  localparam int SUM_OUT_W = c3s_pkg::SUM_OUT_W;

  // configuration registers
  logic [c3s_pkg::CFG_W-1:0]  coeff_r [3];
  logic [c3s_pkg::STEP_W-1:0] step_r;
  logic [c3s_pkg::FW_W-1:0]   fwidth_r;
  logic [ROW_W-1:0]           fheight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r[0] <= '0;
      coeff_r[1] <= '0;
      coeff_r[2] <= '0;
      step_r     <= c3s_pkg::STEP_W'(1);
      fwidth_r   <= c3s_pkg::FW_W'(50);
      fheight_r  <= ROW_W'(50);
    end else if (cfg_we) begin
      case (c3s_pkg::cfg_idx_t'(cfg_index))
        c3s_pkg::CFG_COEFF_TOP: coeff_r[0] <= cfg_wdata;
        c3s_pkg::CFG_COEFF_MID: coeff_r[1] <= cfg_wdata;
        c3s_pkg::CFG_COEFF_BOT: coeff_r[2] <= cfg_wdata;
        c3s_pkg::CFG_STEP:      step_r     <= cfg_wdata[c3s_pkg::STEP_W-1:0];
        c3s_pkg::CFG_FRAME_W:   fwidth_r   <= cfg_wdata[c3s_pkg::FW_W-1:0];
        c3s_pkg::CFG_FRAME_H:   fheight_r  <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [c3s_pkg::STEP_W-1:0] s_eff;
  logic [CW:0]                w_eff;
  logic [ROW_W-1:0]           h_eff;
  logic [CW-1:0]              col_lim;
  logic [ROW_W-1:0]           row_lim;

  always_comb begin
    s_eff = (step_r == '0) ? c3s_pkg::STEP_W'(1) : step_r;
    if (32'(fwidth_r) > MAX_WIDTH) begin
      w_eff = (CW + 1)'(MAX_WIDTH);
    end else if (fwidth_r < c3s_pkg::FW_W'(3)) begin
      w_eff = (CW + 1)'(3);
    end else begin
      w_eff = (CW + 1)'(fwidth_r);
    end
    h_eff   = (fheight_r < ROW_W'(3)) ? ROW_W'(3) : fheight_r;
    col_lim = CW'(w_eff - (CW + 1)'(2));
    row_lim = h_eff - ROW_W'(2);
  end

  // pipeline flow control
  logic v1_r, v2_r, out_valid_r;
  logic ld1, ld2, ld3;
  logic accept;
  c3s_pkg::c3s_ctl_t ctl;

  assign ld3        = !out_valid_r || !out_stall;
  assign ld2        = !v2_r || ld3;
  assign ld1        = !v1_r || ld2;
  assign in_stall   = !ld1;
  assign accept     = in_valid && ld1;
  assign ctl.accept = accept;
  assign ctl.ld2    = ld2;

  // raster position counters
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             pre_hit;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if ({1'b0, col_r} >= w_eff - (CW + 1)'(1)) begin
      col_nxt = '0;
      row_nxt = (row_r >= h_eff - ROW_W'(1)) ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + CW'(1);
    end
    pre_hit = (row_r >= ROW_W'(2)) && (col_r >= CW'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // channel sum of the incoming pixel
  logic [SUM_W-1:0] pix_sum;

  always_comb begin
    pix_sum = SUM_W'(in_sample_ch0);
    if (CHANNELS > 1) begin
      pix_sum = pix_sum + SUM_W'(in_sample_ch1);
    end
    if (CHANNELS > 2) begin
      pix_sum = pix_sum + SUM_W'(in_sample_ch2);
    end
  end

  // line stores: upper half two rows up, lower half one row up
  logic [2*SUM_W-1:0] ls_rdata;
  logic [2*SUM_W-1:0] ls_wdata;
  logic [CW-1:0]      ls_raddr;
  logic [SUM_W-1:0]   above2;
  logic [SUM_W-1:0]   above1;

  assign above2   = ls_rdata[2*SUM_W-1:SUM_W];
  assign above1   = ls_rdata[SUM_W-1:0];
  assign ls_wdata = {above1, pix_sum};
  assign ls_raddr = accept ? col_nxt : col_r;

  c3s_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (2 * SUM_W)
  ) u_line_mem (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (ls_wdata),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  // window cell chain, new column enters at the right
  logic [2:0][SUM_W-1:0]    col_w [4];
  logic signed [PSUM_W-1:0] psum_w [3];

  assign col_w[3] = {pix_sum, above1, above2};

  for (genvar i = 0; i < 3; i++) begin : g_cell
    logic [2:0][c3s_pkg::COEF_W-1:0] coef;

    for (genvar r = 0; r < 3; r++) begin : g_coef
      assign coef[r] = coeff_r[r][c3s_pkg::COEF_W*i +: c3s_pkg::COEF_W];
    end

    c3s_cell #(
      .SUM_W  (SUM_W),
      .PROD_W (PROD_W),
      .PSUM_W (PSUM_W)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .coef_i (coef),
      .col_i  (col_w[i+1]),
      .col_o  (col_w[i]),
      .psum_o (psum_w[i])
    );
  end

  // stride grid units
  logic [ROW_W-1:0]   row_q;
  logic [CW-1:0]      col_q;
  c3s_pkg::c3s_grid_t row_grid;
  c3s_pkg::c3s_grid_t col_grid;

  c3s_grid_div #(
    .X_W (ROW_W)
  ) u_row_grid (
    .clk    (clk),
    .ctl    (ctl),
    .step_i (s_eff),
    .lim_i  (row_lim),
    .x_i    (row_r - ROW_W'(2)),
    .q_o    (row_q),
    .grid_o (row_grid)
  );

  c3s_grid_div #(
    .X_W (CW)
  ) u_col_grid (
    .clk    (clk),
    .ctl    (ctl),
    .step_i (s_eff),
    .lim_i  (col_lim),
    .x_i    (col_r - CW'(2)),
    .q_o    (col_q),
    .grid_o (col_grid)
  );

  // stage valids
  logic v1_nxt, v2_nxt, out_valid_nxt;

  always_comb begin
    v1_nxt        = ld1 ? (accept && pre_hit) : v1_r;
    v2_nxt        = ld2 ? v1_r : v2_r;
    out_valid_nxt = ld3 ? (v2_r && row_grid.hit && col_grid.hit) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  logic signed [PSUM_W+1:0]  total;
  logic [SUM_OUT_W-1:0]      out_sum_r;
  logic [ROW_W-1:0]          out_row_r;
  logic [OUT_COL_W-1:0]      out_col_r;
  logic                      out_last_r;

  assign total = (PSUM_W + 2)'(psum_w[0]) + (PSUM_W + 2)'(psum_w[1])
               + (PSUM_W + 2)'(psum_w[2]);

  always_ff @(posedge clk) begin
    if (ld3) begin
      out_sum_r  <= total[SUM_OUT_W-1:0];
      out_row_r  <= row_q;
      out_col_r  <= OUT_COL_W'(col_q);
      out_last_r <= row_grid.last && col_grid.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_sum = out_sum_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_last = out_last_r;

endmodule
